@@ rtl/core/wpm_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants of the wildcard pattern matcher.
// ---------------------------------------------------------------------------
package wpm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int COL_W       = MAX_PATTERN + 1;
    localparam int LEN_W       = 6;
    localparam int POS_W       = 5;
    localparam int CHAR_W      = 8;
    localparam int MODE_W      = 2;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [CHAR_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [CHAR_W-1:0] ANY_BYTE  = 8'h3F;

    // register index, taken from paddr[2]
    localparam logic REG_PATTERN_LEN = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_TEXT  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // one strobe each for load, start and text items, raised when the item leaves the input register
    typedef struct packed {
        logic load;
        logic start;
        logic text;
    } col_ctrl_t;

    typedef struct packed {
        logic matched;
        logic still_possible;
    } col_result_t;

endpackage
`default_nettype wire

@@ rtl/core/wpm_in_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// wpm_in_if
// Input item channel: pattern loads, text starts and text bytes.
// ---------------------------------------------------------------------------
interface wpm_in_if;
    logic                        valid;
    logic                        ready;
    logic [wpm_pkg::MODE_W-1:0]  mode;
    logic [wpm_pkg::POS_W-1:0]   position;
    logic [wpm_pkg::CHAR_W-1:0]  char_value;

    modport source (output valid, output mode, output position, output char_value,
                    input ready);
    modport sink   (input valid, input mode, input position, input char_value,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/core/wpm_out_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// wpm_out_if
// Result item channel: match flags after each start or text byte.
// ---------------------------------------------------------------------------
interface wpm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic still_possible;

    modport source (output valid, output matched, output still_possible, input ready);
    modport sink   (input valid, input matched, input still_possible, output ready);
endinterface
`default_nettype wire

@@ rtl/core/wpm_apb.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// wpm_apb
// Configuration register file: holds pattern_len, saturated on use.
// ---------------------------------------------------------------------------
module wpm_apb (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [wpm_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [wpm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [wpm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready,
    output logic      [wpm_pkg::LEN_W-1:0]          used_len
);

    logic [wpm_pkg::LEN_W-1:0] len_reg;
    logic [wpm_pkg::LEN_W-1:0] len_next;
    logic                      wr_en;
    logic                      sel_len;

    assign pready  = 1'b1;
    assign sel_len = (paddr[2] == wpm_pkg::REG_PATTERN_LEN);
    assign wr_en   = psel & penable & pwrite & pready & sel_len;

    always_comb
    begin
        len_next = len_reg;
        if (wr_en)
        begin
            len_next = pwdata[wpm_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_len)
        begin
            prdata = {{(wpm_pkg::APB_DATA_W-wpm_pkg::LEN_W){1'b0}}, len_reg};
        end
    end

    // lengths above the store depth act as the full store
    assign used_len = (len_reg > wpm_pkg::LEN_W'(wpm_pkg::MAX_PATTERN)) ?
                      wpm_pkg::LEN_W'(wpm_pkg::MAX_PATTERN) : len_reg;

endmodule
`default_nettype wire

@@ rtl/core/wpm_column.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// wpm_column
// Pattern store and prefix match column with its single-step update.
// ---------------------------------------------------------------------------
module wpm_column (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire wpm_pkg::col_ctrl_t              ctrl,
    input  wire logic [wpm_pkg::POS_W-1:0]       position,
    input  wire logic [wpm_pkg::CHAR_W-1:0]      char_value,
    input  wire logic [wpm_pkg::LEN_W-1:0]       used_len,
    output wpm_pkg::col_result_t                 result
);

    logic [wpm_pkg::CHAR_W-1:0] store_reg [wpm_pkg::MAX_PATTERN];
    logic [wpm_pkg::COL_W-1:0]  col_reg;
    logic [wpm_pkg::COL_W-1:0]  col_next;
    logic [wpm_pkg::COL_W-1:0]  start_col;
    logic [wpm_pkg::COL_W-1:0]  text_col;
    logic [wpm_pkg::COL_W-1:0]  new_col;
    logic [wpm_pkg::MAX_PATTERN-1:0] is_star;
    logic [wpm_pkg::MAX_PATTERN-1:0] is_hit;
    logic [wpm_pkg::MAX_PATTERN-1:0] in_use;

    // every store position is covered by the position field
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            store_reg[position] <= char_value;
        end
    end

    always_comb
    begin
        for (int i = 0; i < wpm_pkg::MAX_PATTERN; i++)
        begin
            is_star[i] = (store_reg[i] == wpm_pkg::STAR_BYTE);
            is_hit[i]  = (store_reg[i] == wpm_pkg::ANY_BYTE) || (store_reg[i] == char_value);
            in_use[i]  = (wpm_pkg::LEN_W'(i + 1) <= used_len);
        end
    end

    // start: bit 0 plus the run of leading stars
    always_comb
    begin
        start_col    = '0;
        start_col[0] = 1'b1;
        for (int i = 1; i < wpm_pkg::COL_W; i++)
        begin
            start_col[i] = start_col[i-1] & is_star[i-1] & in_use[i-1];
        end
    end

    // text byte: literal or any takes the left bit, star ors in the new bit below
    always_comb
    begin
        text_col = '0;
        for (int i = 1; i < wpm_pkg::COL_W; i++)
        begin
            if (in_use[i-1])
            begin
                if (is_star[i-1])
                begin
                    text_col[i] = col_reg[i] | text_col[i-1];
                end
                else if (is_hit[i-1])
                begin
                    text_col[i] = col_reg[i-1];
                end
            end
        end
    end

    assign new_col = ctrl.start ? start_col : text_col;

    always_comb
    begin
        col_next = col_reg;
        if (ctrl.start || ctrl.text)
        begin
            col_next = new_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= wpm_pkg::COL_W'(1);
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    // bits above the length are always clear in a fresh column
    assign result.matched        = new_col[used_len];
    assign result.still_possible = |new_col;

endmodule
`default_nettype wire

@@ rtl/core/wildcard_pattern_match_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// wildcard_pattern_match_core
// Streaming wildcard matcher with '?' and '*' over a stored pattern.
// ---------------------------------------------------------------------------
// usage:
//   item_in carries mode, position and char_value. mode load writes one
//   pattern byte, mode start opens a new text, mode text feeds one text byte.
//   item_out gives matched and still_possible for every start and text item;
//   load items and the unused mode give no result.
//   pattern_len is written over the apb port at byte address 0 while idle.
// timing:
//   an item is captured in the input register, its column update is
//   combinational and its flags land in the result register as it leaves
//   the input register. one item per cycle is sustained while item_out
//   takes each result as it is offered.
// reset:
//   pattern_len is 0 and the column holds only bit 0. pattern bytes are
//   undefined until loaded.
// stall:
//   while a result waits, the input register still drains items that give
//   no result; an item with a result waits there and item_in.ready drops.
// ---------------------------------------------------------------------------
module wildcard_pattern_match_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    wpm_in_if.sink                                  item_in,
    wpm_out_if.source                               item_out,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [wpm_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [wpm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [wpm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready
);

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [wpm_pkg::MODE_W-1:0]    s1_mode_reg;
    logic [wpm_pkg::POS_W-1:0]     s1_pos_reg;
    logic [wpm_pkg::CHAR_W-1:0]    s1_char_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    wpm_pkg::col_result_t          res_reg;
    wpm_pkg::col_result_t          res_comb;
    wpm_pkg::col_ctrl_t            ctrl;
    logic [wpm_pkg::LEN_W-1:0]     used_len;
    logic                          has_result;
    logic                          out_free;
    logic                          s1_move;
    logic                          in_take;

    wpm_apb u_apb (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .used_len (used_len)
    );

    assign has_result = (s1_mode_reg == wpm_pkg::MODE_START) ||
                        (s1_mode_reg == wpm_pkg::MODE_TEXT);
    assign out_free   = !out_valid_reg || item_out.ready;
    assign s1_move    = s1_valid_reg && (!has_result || out_free);
    assign item_in.ready = !s1_valid_reg || s1_move;
    assign in_take    = item_in.valid && item_in.ready;

    assign ctrl.load  = s1_move && (s1_mode_reg == wpm_pkg::MODE_LOAD);
    assign ctrl.start = s1_move && (s1_mode_reg == wpm_pkg::MODE_START);
    assign ctrl.text  = s1_move && (s1_mode_reg == wpm_pkg::MODE_TEXT);

    wpm_column u_column (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .position   (s1_pos_reg),
        .char_value (s1_char_reg),
        .used_len   (used_len),
        .result     (res_comb)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move && has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (item_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg <= item_in.mode;
            s1_pos_reg  <= item_in.position;
            s1_char_reg <= item_in.char_value;
        end
        if (s1_move && has_result)
        begin
            res_reg <= res_comb;
        end
    end

    assign item_out.valid          = out_valid_reg;
    assign item_out.matched        = res_reg.matched;
    assign item_out.still_possible = res_reg.still_possible;

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wildcard pattern match core. A driver feeds
// load, start and text items from a queue, a shadow copy of the pattern and
// of the prefix column predicts the match flags of each start and text item, and
// a monitor compares each result item in order. Several pattern lengths are
// programmed over the apb port between phases, and both sides idle at random.
// ---------------------------------------------------------------------------
module tb_top;
    import wpm_pkg::*;

    typedef struct packed {
        mode_t               mode;
        logic [POS_W-1:0]    position;
        logic [CHAR_W-1:0]   char_value;
    } match_item_t;

    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 330;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_TAIL  = 6;

    localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_B = 8'h62;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    wire  [APB_DATA_W-1:0]  prdata;
    wire                    pready;

    wpm_in_if  in_bus ();
    wpm_out_if out_bus ();

    wildcard_pattern_match_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_in  (in_bus),
        .item_out (out_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // items waiting for the driver, flags waiting for the monitor
    match_item_t        pending_items[$];
    col_result_t        expected_flags[$];

    // shadow state of the matcher
    logic [CHAR_W-1:0]  pat_mem [MAX_PATTERN];
    logic [COL_W-1:0]   prefix_col = COL_W'(1);
    logic [LEN_W-1:0]   cur_len = '0;

    // pattern as seen by the item generator
    logic [CHAR_W-1:0]  gen_pattern [MAX_PATTERN];
    int                 phase_items;

    int                 src_gap_left;
    int                 sink_hold_left;
    bit                 quiet_tail;
    bit                 pressure_armed;
    bit                 pressure_done;
    int                 mismatch_count;
    col_result_t        want;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int unsigned used_len();
        return (cur_len > LEN_W'(MAX_PATTERN)) ? MAX_PATTERN : cur_len;
    endfunction

    task automatic predict_flags(input match_item_t it);
        logic [COL_W-1:0]   nxt;
        logic               star_run;
        logic               any_bit;
        int unsigned        n;
        col_result_t        res;
        n = used_len();
        nxt = '0;
        case (it.mode)
            MODE_LOAD:
            begin
                pat_mem[it.position] = it.char_value;
            end
            MODE_START, MODE_TEXT:
            begin
                if (it.mode == MODE_START)
                begin
                    // bit 0 plus the run of leading stars
                    nxt[0] = 1'b1;
                    star_run = 1'b1;
                    for (int i = 1; i <= n; i++)
                    begin
                        star_run = star_run && (pat_mem[i-1] == STAR_BYTE);
                        nxt[i] = star_run;
                    end
                end
                else
                begin
                    for (int i = 1; i <= n; i++)
                    begin
                        if (pat_mem[i-1] == STAR_BYTE)
                            nxt[i] = prefix_col[i] | nxt[i-1];
                        else if (pat_mem[i-1] == ANY_BYTE || pat_mem[i-1] == it.char_value)
                            nxt[i] = prefix_col[i-1];
                    end
                end
                prefix_col = nxt;
                any_bit = 1'b0;
                for (int i = 0; i <= n; i++)
                    any_bit = any_bit | prefix_col[i];
                res.matched = prefix_col[n];
                res.still_possible = any_bit;
                expected_flags.push_back(res);
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic logic [POS_W-1:0] rand_pos();
        return POS_W'($urandom_range(0, MAX_PATTERN - 1));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_byte();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_text_byte();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return CHAR_A;
            4, 5:       return CHAR_B;
            6:          return STAR_BYTE;
            7:          return ANY_BYTE;
            default:    return rand_byte();
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_pattern_byte();
        case ($urandom_range(0, 9))
            0, 1, 2:    return STAR_BYTE;
            3, 4:       return ANY_BYTE;
            5, 6, 7:    return CHAR_A;
            8:          return CHAR_B;
            default:    return rand_byte();
        endcase
    endfunction

    task automatic push_item(input mode_t m, input logic [POS_W-1:0] pos,
                             input logic [CHAR_W-1:0] ch);
        match_item_t it;
        it.mode = m;
        it.position = pos;
        it.char_value = ch;
        pending_items.push_back(it);
        if (m == MODE_LOAD)
            gen_pattern[pos] = ch;
        if (m != MODE_NONE)
            phase_items++;
    endtask

    // start item followed by text, mostly shaped to fit the pattern
    task automatic push_text_run();
        int unsigned        n;
        logic [CHAR_W-1:0]  p;
        n = used_len();
        push_item(MODE_START, rand_pos(), rand_byte());
        if ($urandom_range(0, 3) != 0)
        begin
            for (int k = 0; k < n; k++)
            begin
                p = gen_pattern[k];
                if (p == STAR_BYTE)
                    repeat ($urandom_range(0, 3))
                        push_item(MODE_TEXT, rand_pos(), pick_text_byte());
                else if (p == ANY_BYTE)
                    push_item(MODE_TEXT, rand_pos(), rand_byte());
                else
                    push_item(MODE_TEXT, rand_pos(), p);
                case ($urandom_range(0, 39))
                    0: push_item(MODE_LOAD, rand_pos(), pick_pattern_byte());
                    1: push_item(MODE_NONE, rand_pos(), rand_byte());
                    2: push_item(MODE_TEXT, rand_pos(), pick_text_byte());
                    default:
                    begin
                    end
                endcase
            end
            repeat ($urandom_range(0, 1))
                push_item(MODE_TEXT, rand_pos(), pick_text_byte());
        end
        else
        begin
            repeat ($urandom_range(0, n + 4))
                push_item(MODE_TEXT, rand_pos(), pick_text_byte());
        end
    endtask

    // wait until every item is taken and every result is back
    task automatic drain_block(input int tail);
        @(posedge clk);
        while (pending_items.size() != 0 || expected_flags.size() != 0 || in_bus.valid)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_pattern_len(input logic [LEN_W-1:0] len);
        drain_block(DRAIN_TAIL);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PATTERN_LEN, 2'b00};
        pwdata  <= APB_DATA_W'(len);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_len = len;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_bus.valid <= 1'b0;
            src_gap_left = 0;
        end
        else
        begin
            if (in_bus.valid && in_bus.ready)
                predict_flags(pending_items.pop_front());
            if (!(in_bus.valid && !in_bus.ready))
            begin
                if (src_gap_left > 0)
                begin
                    src_gap_left--;
                    in_bus.valid <= 1'b0;
                end
                else if (pending_items.size() == 0)
                begin
                    in_bus.valid <= 1'b0;
                end
                else if (!quiet_tail && $urandom_range(0, 11) == 0)
                begin
                    src_gap_left = $urandom_range(0, 15);
                    in_bus.valid <= 1'b0;
                end
                else
                begin
                    in_bus.valid      <= 1'b1;
                    in_bus.mode       <= pending_items[0].mode;
                    in_bus.position   <= pending_items[0].position;
                    in_bus.char_value <= pending_items[0].char_value;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
            sink_hold_left = 0;
        end
        else
        begin
            if (out_bus.valid && out_bus.ready)
            begin
                if (expected_flags.size() == 0)
                begin
                    $display("%0t ns: result item with none expected, actual matched=%0b still_possible=%0b",
                             $time, out_bus.matched, out_bus.still_possible);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_flags.pop_front();
                    if (out_bus.matched !== want.matched)
                    begin
                        $display("%0t ns: matched expected %0b actual %0b",
                                 $time, want.matched, out_bus.matched);
                        mismatch_count++;
                    end
                    if (out_bus.still_possible !== want.still_possible)
                    begin
                        $display("%0t ns: still_possible expected %0b actual %0b",
                                 $time, want.still_possible, out_bus.still_possible);
                        mismatch_count++;
                    end
                end
            end
            // one long hold-off so the core backs up into its input
            if (pressure_armed && !pressure_done)
            begin
                pressure_done = 1'b1;
                sink_hold_left = LONG_HOLD;
            end
            if (sink_hold_left > 0)
            begin
                sink_hold_left--;
                out_bus.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                sink_hold_left = $urandom_range(0, 15);
                out_bus.ready <= 1'b0;
            end
            else
            begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int unsigned phase_len [NUM_PHASES];
        in_bus.valid      = 1'b0;
        in_bus.mode       = MODE_LOAD;
        in_bus.position   = '0;
        in_bus.char_value = '0;
        out_bus.ready     = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty pattern: only bit 0 of the column counts
        write_pattern_len(6'd0);
        push_item(MODE_START, 5'd0, 8'h00);
        push_item(MODE_TEXT, 5'd31, 8'h00);
        push_item(MODE_NONE, 5'd31, 8'hFF);
        push_item(MODE_TEXT, 5'd0, 8'hFF);

        // "*a?*" against a short text
        write_pattern_len(6'd4);
        push_item(MODE_LOAD, 5'd0, STAR_BYTE);
        push_item(MODE_LOAD, 5'd1, CHAR_A);
        push_item(MODE_LOAD, 5'd2, ANY_BYTE);
        push_item(MODE_LOAD, 5'd3, STAR_BYTE);
        push_item(MODE_START, 5'd31, 8'hFF);
        push_item(MODE_TEXT, 5'd0, CHAR_A);
        push_item(MODE_NONE, 5'd0, 8'h00);
        push_item(MODE_TEXT, 5'd0, 8'h78);
        push_item(MODE_TEXT, 5'd0, 8'h79);

        // all-star pattern, then a load while text is running
        write_pattern_len(6'd2);
        push_item(MODE_LOAD, 5'd0, STAR_BYTE);
        push_item(MODE_LOAD, 5'd1, STAR_BYTE);
        push_item(MODE_START, 5'd0, 8'h00);
        push_item(MODE_TEXT, 5'd0, 8'h7E);
        push_item(MODE_LOAD, 5'd1, 8'h71);
        push_item(MODE_TEXT, 5'd0, 8'h71);
        push_item(MODE_TEXT, 5'd0, 8'h71);

        phase_len[0] = 32;
        phase_len[1] = 63;
        phase_len[2] = 1;
        phase_len[3] = $urandom_range(2, 12);
        phase_len[4] = $urandom_range(0, 63);
        phase_len[5] = $urandom_range(3, 10);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_pattern_len(LEN_W'(phase_len[ph]));
            if (ph == NUM_PHASES - 1)
                quiet_tail = 1'b1;
            phase_items = 0;
            // column carries over the length change until the next start
            if (ph > 0)
                repeat (2) push_item(MODE_TEXT, rand_pos(), pick_text_byte());
            for (int p = 0; p < MAX_PATTERN; p++)
                push_item(MODE_LOAD, POS_W'(p), pick_pattern_byte());
            while (phase_items < PHASE_ITEMS)
                push_text_run();
            if (ph == 1)
                pressure_armed = 1'b1;
        end

        drain_block(DRAIN_TAIL);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
